>>> rtl/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants of the text console engine: item structs,
// item kind codes, character codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Cell layout: attribute in the high byte, character in the low byte
    localparam int CELL_W = 16;

    // Item kind codes
    localparam logic [2:0] KIND_PUT        = 3'd0;
    localparam logic [2:0] KIND_SET_CURSOR = 3'd1;
    localparam logic [2:0] KIND_CLEAR      = 3'd2;
    localparam logic [2:0] KIND_ERASE      = 3'd3;
    localparam logic [2:0] KIND_READ       = 3'd4;

    // Character codes and reset attribute
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] RESET_ATTR = 8'h17;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  char_code;
        logic [4:0]  row_in;
        logic [6:0]  col_in;
        logic [7:0]  attr_in;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_value;
    } t_out_item;

    // Cursor update selected by the controller
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_COL_ZERO,
        CUR_SET,
        CUR_HOME,
        CUR_BACK,
        CUR_FILL_STEP
    } t_cur_op;

    // Walk address counter update
    typedef enum logic [1:0] {
        WALK_HOLD,
        WALK_ZERO,
        WALK_ROW,
        WALK_INC
    } t_walk_op;

    // Cell store write source
    typedef enum logic [1:0] {
        WR_NONE,
        WR_CHAR,
        WR_BLANK_CUR,
        WR_BLANK_WALK
    } t_wr_op;

    // Cell store read source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_INDEX,
        RD_SCROLL
    } t_rd_op;

    typedef struct packed {
        logic     load_item;
        t_cur_op  cur_op;
        logic     attr_load;
        t_walk_op walk_op;
        t_wr_op   wr_op;
        t_rd_op   rd_op;
        logic     val_clear;
        logic     val_load;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       is_newline;
        logic       is_return;
        logic       row_last;
        logic       col_last;
        logic       at_origin;
        logic       idx_ok;
        logic       walk_last;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/tce_ram.sv
// ----------------------------------------------------------------------------
// tce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/tce_ctrl.sv
// ----------------------------------------------------------------------------
// tce_ctrl
// Controller of the text console engine: sequences item decode, cell
// writes, row fills, scrolls, screen clears and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire tce_pkg::t_dp_status i_status,
    output tce_pkg::t_dp_cmd         o_cmd,
    output logic                     o_in_stall
);

    import tce_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_READ,
        S_ERASE_WR,
        S_FILL_ROW,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take items only while idle
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.wr_op   = WR_BLANK_WALK;
                o_cmd.walk_op = WALK_INC;
                if (i_status.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.val_clear = 1'b1;
                n_state         = S_DONE;
                unique case (i_status.kind)
                    KIND_PUT: begin
                        if (i_status.is_newline) begin
                            o_cmd.cur_op = CUR_NEWLINE;
                            if (i_status.row_last) begin
                                o_cmd.walk_op = WALK_ZERO;
                                n_state       = S_SCROLL;
                            end
                        end else if (i_status.is_return) begin
                            o_cmd.cur_op  = CUR_COL_ZERO;
                            o_cmd.walk_op = WALK_ROW;
                            n_state       = S_FILL_ROW;
                        end else begin
                            o_cmd.wr_op  = WR_CHAR;
                            o_cmd.cur_op = CUR_ADVANCE;
                            if (i_status.col_last && i_status.row_last) begin
                                o_cmd.walk_op = WALK_ZERO;
                                n_state       = S_SCROLL;
                            end
                        end
                    end
                    KIND_SET_CURSOR: begin
                        o_cmd.cur_op = CUR_SET;
                    end
                    KIND_CLEAR: begin
                        o_cmd.attr_load = 1'b1;
                        o_cmd.cur_op    = CUR_HOME;
                        o_cmd.walk_op   = WALK_ZERO;
                        n_state         = S_CLEAR;
                    end
                    KIND_ERASE: begin
                        if (!i_status.at_origin) begin
                            o_cmd.cur_op = CUR_BACK;
                            n_state      = S_ERASE_WR;
                        end
                    end
                    KIND_READ: begin
                        if (i_status.idx_ok) begin
                            o_cmd.rd_op = RD_INDEX;
                            n_state     = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.val_load = 1'b1;
                n_state        = S_DONE;
            end
            S_ERASE_WR: begin
                o_cmd.wr_op = WR_BLANK_CUR;
                n_state     = S_DONE;
            end
            S_FILL_ROW: begin
                o_cmd.wr_op   = WR_BLANK_WALK;
                o_cmd.walk_op = WALK_INC;
                o_cmd.cur_op  = CUR_FILL_STEP;
                if (i_status.col_last) begin
                    if (i_status.row_last) begin
                        o_cmd.walk_op = WALK_ZERO;
                        n_state       = S_SCROLL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCROLL: begin
                o_cmd.rd_op   = RD_SCROLL;
                o_cmd.walk_op = WALK_INC;
                if (i_status.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.wr_op   = WR_BLANK_WALK;
                o_cmd.walk_op = WALK_INC;
                if (i_status.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; reset starts the clearing pass over the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tce_datapath.sv
// ----------------------------------------------------------------------------
// tce_datapath
// Datapath of the text console engine: cursor and attribute registers,
// walk address counter, cell store with its write/read muxing, scroll
// copy pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_datapath #(
    parameter int COLUMNS = tce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tce_pkg::DEF_ROWS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tce_pkg::t_dp_cmd  i_cmd,
    input  wire tce_pkg::t_in_item i_in_item,
    input  wire logic              i_out_stall,
    output tce_pkg::t_dp_status    o_status,
    output logic                   o_out_valid,
    output tce_pkg::t_out_item     o_out_item
);

    import tce_pkg::*;

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int COPY_CELLS  = CELLS - COLUMNS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int ROW_W       = $clog2(ROWS);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0]  ROW_PEN   = ROW_W'(ROWS - 2);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] WALK_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

    t_in_item            r_item;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    n_row;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic [7:0]          r_attr;
    logic [ADDR_W-1:0]   r_walk;
    logic [ADDR_W-1:0]   n_walk;
    logic                r_pend_valid;
    logic [ADDR_W-1:0]   r_pend_addr;
    logic                r_pend_copy;
    logic [CELL_W-1:0]   r_value;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [ADDR_W-1:0]   w_row_base;
    logic [ADDR_W-1:0]   w_lin;
    logic                w_copy;
    logic [CELL_W-1:0]   w_blank;
    logic                w_row_last;
    logic                w_col_last;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [CELL_W-1:0]   w_wr_data;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [CELL_W-1:0]   w_rd_data;

    // Linear cell address of the cursor
    assign w_row_base = ADDR_W'(32'(r_row) * COLUMNS);
    assign w_lin      = w_row_base + ADDR_W'(r_col);

    // Scroll step copies from one row below until the last row
    assign w_copy     = (32'(r_walk) < COPY_CELLS);
    assign w_blank    = {r_attr, CH_SPACE};
    assign w_row_last = (r_row == ROW_LAST);
    assign w_col_last = (r_col == COL_LAST);

    // Status toward the controller
    always_comb begin
        o_status.kind       = r_item.kind;
        o_status.is_newline = (r_item.char_code == CH_NEWLINE);
        o_status.is_return  = (r_item.char_code == CH_RETURN);
        o_status.row_last   = w_row_last;
        o_status.col_last   = w_col_last;
        o_status.at_origin  = (r_row == '0) && (r_col == '0);
        o_status.idx_ok     = (32'(r_item.cell_index) < CELLS);
        o_status.walk_last  = (r_walk == WALK_LAST);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    // Cursor update
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        unique case (i_cmd.cur_op)
            CUR_HOLD: begin
                n_row = r_row;
            end
            CUR_ADVANCE: begin
                if (w_col_last) begin
                    n_col = '0;
                    if (!w_row_last) begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            CUR_NEWLINE: begin
                n_col = '0;
                if (!w_row_last) begin
                    n_row = r_row + 1'b1;
                end
            end
            CUR_COL_ZERO: begin
                n_col = '0;
            end
            CUR_SET: begin
                n_row = (32'(r_item.row_in) < ROWS) ? ROW_W'(r_item.row_in) : ROW_LAST;
                n_col = (32'(r_item.col_in) < COLUMNS) ? COL_W'(r_item.col_in) : COL_LAST;
            end
            CUR_HOME: begin
                n_row = '0;
                n_col = '0;
            end
            CUR_BACK: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                end else if (r_row != '0) begin
                    n_row = r_row - 1'b1;
                    n_col = COL_LAST;
                end
            end
            CUR_FILL_STEP: begin
                // Last cell of a fill on the last row wraps and steps up a row before the scroll
                if (w_col_last) begin
                    n_col = '0;
                    if (w_row_last) begin
                        n_row = ROW_PEN;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        endcase
    end

    // Walk address counter
    always_comb begin
        unique case (i_cmd.walk_op)
            WALK_HOLD: n_walk = r_walk;
            WALK_ZERO: n_walk = '0;
            WALK_ROW:  n_walk = w_row_base;
            WALK_INC:  n_walk = r_walk + 1'b1;
        endcase
    end

    // Write port: a pending scroll write takes the port
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_lin;
        w_wr_data = w_blank;
        if (r_pend_valid) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_pend_addr;
            w_wr_data = r_pend_copy ? w_rd_data : w_blank;
        end else begin
            unique case (i_cmd.wr_op)
                WR_NONE: begin
                    w_wr_en = 1'b0;
                end
                WR_CHAR: begin
                    w_wr_en   = 1'b1;
                    w_wr_data = {r_attr, r_item.char_code};
                end
                WR_BLANK_CUR: begin
                    w_wr_en = 1'b1;
                end
                WR_BLANK_WALK: begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_walk;
                end
            endcase
        end
    end

    // Read port
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = ADDR_W'(r_item.cell_index);
        unique case (i_cmd.rd_op)
            RD_INDEX: begin
                w_rd_en = 1'b1;
            end
            RD_SCROLL: begin
                w_rd_en   = w_copy;
                w_rd_addr = r_walk + ROW_STEP;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    tce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_col        <= '0;
            r_attr       <= RESET_ATTR;
            r_walk       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_row        <= n_row;
            r_col        <= n_col;
            r_walk       <= n_walk;
            r_pend_valid <= (i_cmd.rd_op == RD_SCROLL);
            if (i_cmd.attr_load && (r_item.attr_in != 8'd0)) begin
                r_attr <= r_item.attr_in;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        r_pend_addr <= r_walk;
        r_pend_copy <= w_copy;
        if (i_cmd.val_clear) begin
            r_value <= '0;
        end else if (i_cmd.val_load) begin
            r_value <= w_rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_item.cursor_pos <= 11'(w_lin);
            r_out_item.cell_value <= r_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A pending scroll write never meets a command write
    a_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (i_cmd.wr_op == WR_NONE))
        else $error("scroll write collides with a command write");

    // Cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_LAST) && (r_col <= COL_LAST))
        else $error("cursor left the screen");

    // Cell reads only inside the store
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_op == RD_INDEX) |-> (32'(r_item.cell_index) < CELLS))
        else $error("cell read beyond the store");

    // A loaded result is offered in the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not offered");

endmodule

`default_nettype wire

>>> rtl/text_console_engine.sv
// ----------------------------------------------------------------------------
// text_console_engine
// Text-mode console owning a ROWS x COLUMNS cell store (attribute in the
// high byte, character in the low byte).
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one command item:
// put character, set cursor, clear screen, erase previous or read cell.
// Output channel (o_out_valid / i_out_stall / o_out_item) gives exactly one
// result item per command: the cursor position and, for a read, the cell.
// Items are taken one at a time; a waiting result does not block the next
// input item, only the handoff of the following result.
// A scroll (leaving the last row) and a clear both walk the cell RAM, which
// has one write and one read port, one cell per cycle; the result register
// loads once the walk is done.
// Reset homes the cursor, sets the attribute to 0x17 and runs a clearing pass
// over the store, with o_in_stall high. A stalled receiver holds the result
// in place; the engine finishes the next item and then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_engine #(
    parameter int COLUMNS = tce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tce_pkg::DEF_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tce_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tce_pkg::t_out_item      o_out_item
);

    import tce_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequence each item
    tce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold cursor, attribute, store and result
    tce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
